>>> rtl/agcpi_pkg.sv
`default_nettype none

package agcpi_pkg;

	localparam int PULSE_PAIRS = 6;
	localparam int POS_W = 17;
	localparam int MAG_W = 35;

	localparam logic [30:0] RECIP_107 = 31'd1284476201;
	localparam logic [29:0] DIV_107 = 30'd107;
	localparam logic [25:0] RECIP_255 = 26'd33686019;
	localparam logic [23:0] HALF_255 = 24'd127;
	localparam logic [16:0] Q16_AGC = 17'd72090;
	localparam logic [11:0] Q16_PSYNC = 12'd3932;
	localparam logic [MAG_W:0] Q16_HALF = 36'd32768;

	localparam logic signed [11:0] TRI_OFS = 12'sd856;
	localparam logic [10:0] GREY_FLOOR = 11'd150;
	localparam logic [10:0] GREY_CEIL = 11'd405;
	localparam logic [7:0] GREY_MAX = 8'd255;

	localparam logic [9:0] LINE_AGC = 10'd1;
	localparam logic [9:0] L625_A_LO = 10'd9;
	localparam logic [9:0] L625_A_HI = 10'd18;
	localparam logic [9:0] L625_B_LO = 10'd321;
	localparam logic [9:0] L625_B_HI = 10'd330;
	localparam logic [9:0] L525_A_LO = 10'd12;
	localparam logic [9:0] L525_A_HI = 10'd19;
	localparam logic [9:0] L525_B_LO = 10'd275;
	localparam logic [9:0] L525_B_HI = 10'd282;

	localparam logic [2:0] REG_LINES_625 = 3'd0;
	localparam logic [2:0] REG_TIP_LVL = 3'd1;
	localparam logic [2:0] REG_BLACK_LEVEL = 3'd2;
	localparam logic [2:0] REG_PEAK_LVL = 3'd3;
	localparam logic [2:0] REG_FIRST_LEFT = 3'd4;
	localparam logic [2:0] REG_PULSE_SPACING = 3'd5;
	localparam logic [2:0] REG_PS_WIDTH = 3'd6;
	localparam logic [2:0] REG_AGC_WIDTH = 3'd7;

	typedef enum logic [1:0] {
		SEL_NONE = 2'd0,
		SEL_PSYNC = 2'd1,
		SEL_AGC = 2'd2
	} sel_t;

	typedef struct packed {
		logic claim;
		sel_t sel;
	} pick_t;

	typedef struct packed {
		logic lines_625;
		logic signed [15:0] tip_lvl;
		logic signed [15:0] black_level;
		logic signed [15:0] peak_lvl;
		logic [11:0] first_left;
		logic [11:0] pulse_spacing;
		logic [11:0] ps_width;
		logic [11:0] agc_width;
	} cfg_t;

	typedef struct packed {
		logic line1;
		pick_t pick;
		logic signed [15:0] smp;
	} side_t;

endpackage

`default_nettype wire

>>> rtl/agcpi_round_sat.sv
`default_nettype none

module agcpi_round_sat (
	input wire logic [agcpi_pkg::MAG_W-1:0] mag,
	input wire logic neg,
	input wire logic signed [15:0] base,
	output logic signed [15:0] level
);

	always_comb begin
		logic [agcpi_pkg::MAG_W:0] sum;
		logic [19:0] q;
		logic signed [20:0] qs;
		logic signed [20:0] res;
		sum = {1'b0, mag} + agcpi_pkg::Q16_HALF;
		q = sum[agcpi_pkg::MAG_W:16];
		qs = $signed({1'b0, q});
		res = 21'(base) + (neg ? -qs : qs);
		if (res > 21'sd32767) begin
			level = 16'sh7fff;
		end else if (res < -21'sd32768) begin
			level = 16'sh8000;
		end else begin
			level = res[15:0];
		end
	end

endmodule

`default_nettype wire

>>> rtl/agcpi_pulse_sel.sv
`default_nettype none

module agcpi_pulse_sel (
	input wire logic [9:0] line_number,
	input wire logic [11:0] pixel_pos,
	input wire logic line_taken,
	input wire agcpi_pkg::cfg_t cfg,
	output agcpi_pkg::pick_t pick
);

	always_comb begin
		logic win;
		logic [agcpi_pkg::POS_W-1:0] l0;
		logic [agcpi_pkg::POS_W-1:0] l1;
		logic [agcpi_pkg::POS_W-1:0] l2;
		logic [agcpi_pkg::POS_W-1:0] x;
		agcpi_pkg::sel_t sel;
		if (cfg.lines_625) begin
			win = (line_number >= agcpi_pkg::L625_A_LO && line_number <= agcpi_pkg::L625_A_HI) ||
				(line_number >= agcpi_pkg::L625_B_LO && line_number <= agcpi_pkg::L625_B_HI);
		end else begin
			win = (line_number >= agcpi_pkg::L525_A_LO && line_number <= agcpi_pkg::L525_A_HI) ||
				(line_number >= agcpi_pkg::L525_B_LO && line_number <= agcpi_pkg::L525_B_HI);
		end
		x = agcpi_pkg::POS_W'(pixel_pos);
		sel = agcpi_pkg::SEL_NONE;
		// later pairs win where pairs overlap
		for (int k = 0; k < agcpi_pkg::PULSE_PAIRS; k++) begin
			l0 = agcpi_pkg::POS_W'(cfg.first_left) +
				agcpi_pkg::POS_W'(cfg.pulse_spacing) * agcpi_pkg::POS_W'(k);
			l1 = l0 + agcpi_pkg::POS_W'(cfg.ps_width);
			l2 = l1 + agcpi_pkg::POS_W'(cfg.agc_width);
			if (x >= l0 && x < l1) begin
				sel = agcpi_pkg::SEL_PSYNC;
			end else if (x >= l1 && x < l2) begin
				sel = agcpi_pkg::SEL_AGC;
			end
		end
		pick.claim = win && !line_taken;
		pick.sel = pick.claim ? sel : agcpi_pkg::SEL_NONE;
	end

endmodule

`default_nettype wire

>>> rtl/agc_pulse_inserter.sv
// agc pulse inserter
// input stream: one video sample per request, s_axis_tdata carries line number,
// frame number, pixel position and sample; s_axis_tuser flags a line already
// taken by another source. output stream: one sample per request with the
// claim flag in m_axis_tuser.
// one sample is accepted every cycle while the output is taken. the nine
// register stages carry the agc level arithmetic: frame mod 428 by
// reciprocal multiply, grey map with divide by 255, then the 1.10 scale
// with rounding and saturation.
// a line-1 sample loads the new agc level as it enters the output register,
// so every later sample sees it.
// configuration through the apb port must be written only while the stream
// is idle; the block does not enforce it. reset clears all stage valid bits,
// the agc level (0) and the registers (lines_625 = 1, others 0).
// when the receiver stalls, stages hold their data and bubbles fill up before
// s_axis_tready drops; nothing is lost or repeated.
`default_nettype none

module agc_pulse_inserter (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	// [9:0] line_number, [41:10] frame_number, [53:42] pixel_pos, [69:54] sample_in
	input wire logic [71:0] s_axis_tdata,
	// [0] line_taken
	input wire logic s_axis_tuser,
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	// [15:0] sample_out
	output logic [15:0] m_axis_tdata,
	// [0] line_claimed
	output logic m_axis_tuser,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [4:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	agcpi_pkg::cfg_t cfg_q;
	logic signed [15:0] agc_level_q;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7, rdy8, rdy9;

	agcpi_pkg::side_t side_s1, side_s2, side_s3, side_s4, side_s5, side_s6, side_s7, side_s8;
	logic [29:0] f2_s1;
	logic [1:0] fl_s1, fl_s2;
	logic [60:0] p1_s1;
	logic [6:0] rem_s2;
	logic [28:0] pp_s2;
	logic ppn_s2;
	logic [7:0] g_s3;
	logic signed [25:0] n_s4;
	logic [49:0] pq_s5;
	logic neg_s5;
	logic signed [17:0] lv_s6;
	logic [34:0] pa_s7;
	logic neg_s7;
	logic signed [15:0] agcn_s8;
	logic signed [15:0] psync_s3, psync_s4, psync_s5, psync_s6, psync_s7, psync_s8;
	logic [15:0] smp_s9;
	logic claim_s9;

	agcpi_pkg::pick_t pick_in;
	agcpi_pkg::side_t side_in;
	logic [60:0] p1_in;
	logic [6:0] rem_in;
	logic [28:0] pp_in;
	logic ppn_in;
	logic [7:0] g_in;
	logic signed [25:0] n_in;
	logic [49:0] pq_in;
	logic neg5_in;
	logic signed [17:0] lv_in;
	logic [34:0] pa_in;
	logic neg7_in;
	logic signed [15:0] psync_in;
	logic signed [15:0] agcn_in;
	logic [15:0] smp_out_in;
	logic wr_en;

	// configuration port
	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lines_625 <= 1'b1;
			cfg_q.tip_lvl <= '0;
			cfg_q.black_level <= '0;
			cfg_q.peak_lvl <= '0;
			cfg_q.first_left <= '0;
			cfg_q.pulse_spacing <= '0;
			cfg_q.ps_width <= '0;
			cfg_q.agc_width <= '0;
		end else if (wr_en) begin
			case (paddr[4:2])
				agcpi_pkg::REG_LINES_625: cfg_q.lines_625 <= pwdata[0];
				agcpi_pkg::REG_TIP_LVL: cfg_q.tip_lvl <= pwdata[15:0];
				agcpi_pkg::REG_BLACK_LEVEL: cfg_q.black_level <= pwdata[15:0];
				agcpi_pkg::REG_PEAK_LVL: cfg_q.peak_lvl <= pwdata[15:0];
				agcpi_pkg::REG_FIRST_LEFT: cfg_q.first_left <= pwdata[11:0];
				agcpi_pkg::REG_PULSE_SPACING: cfg_q.pulse_spacing <= pwdata[11:0];
				agcpi_pkg::REG_PS_WIDTH: cfg_q.ps_width <= pwdata[11:0];
				agcpi_pkg::REG_AGC_WIDTH: cfg_q.agc_width <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			agcpi_pkg::REG_LINES_625: prdata = 32'(cfg_q.lines_625);
			agcpi_pkg::REG_TIP_LVL: prdata = 32'(cfg_q.tip_lvl);
			agcpi_pkg::REG_BLACK_LEVEL: prdata = 32'(cfg_q.black_level);
			agcpi_pkg::REG_PEAK_LVL: prdata = 32'(cfg_q.peak_lvl);
			agcpi_pkg::REG_FIRST_LEFT: prdata = 32'(cfg_q.first_left);
			agcpi_pkg::REG_PULSE_SPACING: prdata = 32'(cfg_q.pulse_spacing);
			agcpi_pkg::REG_PS_WIDTH: prdata = 32'(cfg_q.ps_width);
			agcpi_pkg::REG_AGC_WIDTH: prdata = 32'(cfg_q.agc_width);
			default: prdata = '0;
		endcase
	end

	// per-stage ready, bubbles are filled while the output stalls
	assign rdy9 = !vld_s9 || m_axis_tready;
	assign rdy8 = !vld_s8 || rdy9;
	assign rdy7 = !vld_s7 || rdy8;
	assign rdy6 = !vld_s6 || rdy7;
	assign rdy5 = !vld_s5 || rdy6;
	assign rdy4 = !vld_s4 || rdy5;
	assign rdy3 = !vld_s3 || rdy4;
	assign rdy2 = !vld_s2 || rdy3;
	assign rdy1 = !vld_s1 || rdy2;
	assign s_axis_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
			agc_level_q <= '0;
		end else begin
			if (rdy1) vld_s1 <= s_axis_tvalid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
			if (rdy5) vld_s5 <= vld_s4;
			if (rdy6) vld_s6 <= vld_s5;
			if (rdy7) vld_s7 <= vld_s6;
			if (rdy8) vld_s8 <= vld_s7;
			if (rdy9) vld_s9 <= vld_s8;
			if (rdy9 && vld_s8 && side_s8.line1) begin
				agc_level_q <= agcn_s8;
			end
		end
	end

	// stage 1: window and pulse match, frame reciprocal product
	agcpi_pulse_sel u_pulse_sel (
		.line_number(s_axis_tdata[9:0]),
		.pixel_pos(s_axis_tdata[53:42]),
		.line_taken(s_axis_tuser),
		.cfg(cfg_q),
		.pick(pick_in)
	);

	always_comb begin
		side_in.line1 = s_axis_tdata[9:0] == agcpi_pkg::LINE_AGC;
		side_in.pick = pick_in;
		side_in.smp = s_axis_tdata[69:54];
		p1_in = 61'(s_axis_tdata[41:12]) * 61'(agcpi_pkg::RECIP_107);
	end

	// stage 2: remainder of frame/4 by 107, psync product
	always_comb begin
		logic [29:0] qm;
		logic [29:0] diff;
		logic signed [16:0] wsd;
		logic [16:0] wsm;
		qm = 30'(p1_s1[60:37]) * agcpi_pkg::DIV_107;
		diff = f2_s1 - qm;
		rem_in = diff[6:0];
		wsd = 17'(cfg_q.peak_lvl) - 17'(cfg_q.tip_lvl);
		wsm = wsd[16] ? 17'(-wsd) : 17'(wsd);
		ppn_in = wsd[16];
		pp_in = 29'(wsm) * 29'(agcpi_pkg::Q16_PSYNC);
	end

	// stage 3: clipped triangle grey value, psync level
	always_comb begin
		logic [8:0] fm;
		logic signed [11:0] t;
		logic [10:0] ta;
		fm = {rem_s2, fl_s2};
		t = $signed({1'b0, fm, 2'b00}) - agcpi_pkg::TRI_OFS;
		ta = t[11] ? 11'(-t) : 11'(t);
		if (ta < agcpi_pkg::GREY_FLOOR) begin
			g_in = '0;
		end else if (ta > agcpi_pkg::GREY_CEIL) begin
			g_in = agcpi_pkg::GREY_MAX;
		end else begin
			g_in = 8'(ta - agcpi_pkg::GREY_FLOOR);
		end
	end

	agcpi_round_sat u_round_psync (
		.mag(agcpi_pkg::MAG_W'(pp_s2)),
		.neg(ppn_s2),
		.base(cfg_q.tip_lvl),
		.level(psync_in)
	);

	// stage 4: grey times swing
	always_comb begin
		logic signed [16:0] wbd;
		logic signed [25:0] gs;
		wbd = 17'(cfg_q.peak_lvl) - 17'(cfg_q.black_level);
		gs = $signed({18'd0, g_s3});
		n_in = 26'(wbd) * gs;
	end

	// stage 5: divide by 255 with rounding, reciprocal product
	always_comb begin
		logic [23:0] nm;
		logic [23:0] w;
		nm = n_s4[25] ? 24'(-n_s4) : 24'(n_s4);
		w = nm + agcpi_pkg::HALF_255;
		neg5_in = n_s4[25];
		pq_in = 50'(w) * 50'(agcpi_pkg::RECIP_255);
	end

	// stage 6: mapped level
	always_comb begin
		logic signed [17:0] qs;
		qs = $signed({1'b0, pq_s5[49:33]});
		lv_in = 18'(cfg_q.black_level) + (neg_s5 ? -qs : qs);
	end

	// stage 7: 1.10 scale product
	always_comb begin
		logic signed [18:0] d;
		logic [17:0] dm;
		d = 19'(lv_s6) - 19'(cfg_q.tip_lvl);
		dm = d[18] ? 18'(-d) : 18'(d);
		neg7_in = d[18];
		pa_in = 35'(dm) * 35'(agcpi_pkg::Q16_AGC);
	end

	// stage 8: round and saturate new agc level
	agcpi_round_sat u_round_agc (
		.mag(pa_s7),
		.neg(neg_s7),
		.base(cfg_q.tip_lvl),
		.level(agcn_in)
	);

	// stage 9: sample choice
	always_comb begin
		case (side_s8.pick.sel)
			agcpi_pkg::SEL_PSYNC: smp_out_in = psync_s8;
			agcpi_pkg::SEL_AGC: smp_out_in = agc_level_q;
			default: smp_out_in = side_s8.smp;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			side_s1 <= side_in;
			f2_s1 <= s_axis_tdata[41:12];
			fl_s1 <= s_axis_tdata[11:10];
			p1_s1 <= p1_in;
		end
		if (rdy2) begin
			side_s2 <= side_s1;
			fl_s2 <= fl_s1;
			rem_s2 <= rem_in;
			pp_s2 <= pp_in;
			ppn_s2 <= ppn_in;
		end
		if (rdy3) begin
			side_s3 <= side_s2;
			g_s3 <= g_in;
			psync_s3 <= psync_in;
		end
		if (rdy4) begin
			side_s4 <= side_s3;
			n_s4 <= n_in;
			psync_s4 <= psync_s3;
		end
		if (rdy5) begin
			side_s5 <= side_s4;
			pq_s5 <= pq_in;
			neg_s5 <= neg5_in;
			psync_s5 <= psync_s4;
		end
		if (rdy6) begin
			side_s6 <= side_s5;
			lv_s6 <= lv_in;
			psync_s6 <= psync_s5;
		end
		if (rdy7) begin
			side_s7 <= side_s6;
			pa_s7 <= pa_in;
			neg_s7 <= neg7_in;
			psync_s7 <= psync_s6;
		end
		if (rdy8) begin
			side_s8 <= side_s7;
			agcn_s8 <= agcn_in;
			psync_s8 <= psync_s7;
		end
		if (rdy9) begin
			smp_s9 <= smp_out_in;
			claim_s9 <= side_s8.pick.claim;
		end
	end

	assign m_axis_tvalid = vld_s9;
	assign m_axis_tdata = smp_s9;
	assign m_axis_tuser = claim_s9;

	a_agc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(rdy9 && vld_s8 && side_s8.line1) |=> $stable(agc_level_q))
		else $error("agc level changed without a line 1 sample");

	a_pulse_claims: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && side_s1.pick.sel != agcpi_pkg::SEL_NONE |-> side_s1.pick.claim)
		else $error("pulse selected on an unclaimed line");

	a_full_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 &&
			vld_s6 && vld_s7 && vld_s8 && vld_s9)
		else $error("input stalled while the pipeline has a bubble");

endmodule

`default_nettype wire

>>> tb/agc_pulse_inserter_test.sv
`default_nettype none

module agc_pulse_inserter_test;

	typedef struct {
		logic [9:0] line;
		logic [31:0] frame;
		logic [11:0] pixel;
		logic signed [15:0] smp;
		logic taken;
	} video_sample_t;

	typedef struct {
		logic signed [15:0] smp;
		logic claim;
	} pulse_out_t;

	class pulse_scoreboard;
		agcpi_pkg::cfg_t cfg;
		logic signed [15:0] agc_level;
		pulse_out_t samples_due[$];
		int errors;
		int checked;
		int overwritten;
		int claimed;

		function new();
			cfg = '0;
			cfg.lines_625 = 1'b1;
			agc_level = '0;
			errors = 0;
			checked = 0;
			overwritten = 0;
			claimed = 0;
		endfunction

		function longint s16(logic [15:0] v);
			return longint'($signed(v));
		endfunction

		function longint round_q16(longint p);
			longint m;
			longint q;
			m = (p < 0) ? -p : p;
			q = (m + 32768) >> 16;
			return (p < 0) ? -q : q;
		endfunction

		function longint round_div255(longint n);
			longint m;
			longint q;
			m = (n < 0) ? -n : n;
			q = (2 * m + 255) / 510;
			return (n < 0) ? -q : q;
		endfunction

		function logic signed [15:0] level_from_sync(longint target, longint factor);
			longint v;
			v = s16(cfg.tip_lvl) + round_q16((target - s16(cfg.tip_lvl)) * factor);
			if (v > 32767)
				return 16'sh7fff;
			if (v < -32768)
				return 16'sh8000;
			return v[15:0];
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] val);
			case (idx)
				agcpi_pkg::REG_LINES_625: cfg.lines_625 = val[0];
				agcpi_pkg::REG_TIP_LVL: cfg.tip_lvl = val[15:0];
				agcpi_pkg::REG_BLACK_LEVEL: cfg.black_level = val[15:0];
				agcpi_pkg::REG_PEAK_LVL: cfg.peak_lvl = val[15:0];
				agcpi_pkg::REG_FIRST_LEFT: cfg.first_left = val[11:0];
				agcpi_pkg::REG_PULSE_SPACING: cfg.pulse_spacing = val[11:0];
				agcpi_pkg::REG_PS_WIDTH: cfg.ps_width = val[11:0];
				agcpi_pkg::REG_AGC_WIDTH: cfg.agc_width = val[11:0];
				default: ;
			endcase
		endfunction

		function void note_input(video_sample_t s);
			pulse_out_t o;
			int t;
			int g;
			longint lv;
			longint l0;
			longint l1;
			longint l2;
			longint x;
			logic in_window;
			logic signed [15:0] ps_lvl;

			// agc level follows a clipped triangle of the frame count
			if (s.line == agcpi_pkg::LINE_AGC) begin
				t = int'(s.frame % 428) * 4 - 856;
				if (t < 0)
					t = -t;
				g = t - 150;
				if (g < 0)
					g = 0;
				if (g > 255)
					g = 255;
				lv = s16(cfg.black_level) +
					round_div255((s16(cfg.peak_lvl) - s16(cfg.black_level)) * g);
				agc_level = level_from_sync(lv, longint'(agcpi_pkg::Q16_AGC));
			end

			if (cfg.lines_625)
				in_window = (s.line >= agcpi_pkg::L625_A_LO && s.line <= agcpi_pkg::L625_A_HI) ||
					(s.line >= agcpi_pkg::L625_B_LO && s.line <= agcpi_pkg::L625_B_HI);
			else
				in_window = (s.line >= agcpi_pkg::L525_A_LO && s.line <= agcpi_pkg::L525_A_HI) ||
					(s.line >= agcpi_pkg::L525_B_LO && s.line <= agcpi_pkg::L525_B_HI);

			o.smp = s.smp;
			o.claim = 1'b0;
			if (in_window && !s.taken) begin
				ps_lvl = level_from_sync(s16(cfg.peak_lvl), longint'(agcpi_pkg::Q16_PSYNC));
				x = longint'(s.pixel);
				for (int k = 0; k < agcpi_pkg::PULSE_PAIRS; k++) begin
					l0 = longint'(cfg.first_left) + longint'(k) * longint'(cfg.pulse_spacing);
					l1 = l0 + longint'(cfg.ps_width);
					l2 = l1 + longint'(cfg.agc_width);
					if (x >= l0 && x < l1)
						o.smp = ps_lvl;
					else if (x >= l1 && x < l2)
						o.smp = agc_level;
				end
				if (o.smp !== s.smp)
					overwritten++;
				o.claim = 1'b1;
				claimed++;
			end
			samples_due.push_back(o);
		endfunction

		function void check_result(logic signed [15:0] smp, logic claim);
			pulse_out_t want;
			if (samples_due.size() == 0) begin
				$display("%0t: unexpected output sample %0d claim %0b", $time, smp, claim);
				errors++;
				return;
			end
			want = samples_due.pop_front();
			checked++;
			if (smp !== want.smp) begin
				$display("%0t: sample_out mismatch, expected %0d, got %0d",
					$time, want.smp, smp);
				errors++;
			end
			if (claim !== want.claim) begin
				$display("%0t: line_claimed mismatch, expected %0b, got %0b",
					$time, want.claim, claim);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [71:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic m_axis_tuser;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	pulse_scoreboard sb = new();
	video_sample_t samples_to_send[$];
	int settings_count = 0;
	int samples_sent = 0;

	agc_pulse_inserter dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

	// receiver stalls in segments of varying character
	initial begin
		int mode;
		int seg;
		forever begin
			mode = $urandom_range(0, 3);
			seg = $urandom_range(20, 150);
			for (int i = 0; i < seg; i++) begin
				@(posedge clk);
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= ($urandom_range(0, 3) != 0);
					2: m_axis_tready <= ((i % 8) < 5);
					default: m_axis_tready <= ((i % 24) >= 12);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser);
	end

	function automatic void add_sample(int line, logic [31:0] frame, int pixel, int smp,
		bit taken);
		video_sample_t s;
		s.line = line[9:0];
		s.frame = frame;
		s.pixel = pixel[11:0];
		s.smp = smp[15:0];
		s.taken = taken;
		samples_to_send.push_back(s);
	endfunction

	function automatic video_sample_t random_sample();
		video_sample_t s;
		int r;
		int base;
		int p;
		bit use_625;
		int edge_lines[11] = '{0, 8, 11, 19, 20, 274, 283, 320, 331, 625, 626};
		r = $urandom_range(0, 99);
		use_625 = (r < 65) ? sb.cfg.lines_625 : !sb.cfg.lines_625;
		if (r < 15)
			s.line = agcpi_pkg::LINE_AGC;
		else if (r < 72) begin
			if (use_625)
				s.line = 10'($urandom_range(0, 1) ?
					$urandom_range(agcpi_pkg::L625_A_LO, agcpi_pkg::L625_A_HI) :
					$urandom_range(agcpi_pkg::L625_B_LO, agcpi_pkg::L625_B_HI));
			else
				s.line = 10'($urandom_range(0, 1) ?
					$urandom_range(agcpi_pkg::L525_A_LO, agcpi_pkg::L525_A_HI) :
					$urandom_range(agcpi_pkg::L525_B_LO, agcpi_pkg::L525_B_HI));
		end else if (r < 80)
			s.line = 10'(edge_lines[$urandom_range(0, 10)]);
		else
			s.line = 10'($urandom_range(0, 1023));
		s.frame = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 1711);
		p = -1;
		if ($urandom_range(0, 99) < 65) begin
			base = sb.cfg.first_left +
				$urandom_range(0, agcpi_pkg::PULSE_PAIRS - 1) * sb.cfg.pulse_spacing;
			p = base + $urandom_range(0, sb.cfg.ps_width + sb.cfg.agc_width + 2) - 1;
		end
		if (p < 0 || p > 4095)
			p = $urandom_range(0, 4095);
		s.pixel = p[11:0];
		s.smp = 16'($urandom_range(0, 65535));
		s.taken = ($urandom_range(0, 3) == 0);
		return s;
	endfunction

	function automatic agcpi_pkg::cfg_t pick_settings(int phase);
		agcpi_pkg::cfg_t c;
		case (phase)
			0: begin
				c.lines_625 = 1'b1;
				c.tip_lvl = 16'sh8000;
				c.black_level = 16'sh8000;
				c.peak_lvl = 16'sh7fff;
				c.first_left = 12'd0;
				c.pulse_spacing = 12'd0;
				c.ps_width = 12'd4095;
				c.agc_width = 12'd4095;
			end
			1: begin
				c.lines_625 = 1'b0;
				c.tip_lvl = 16'sh7fff;
				c.black_level = 16'sh7fff;
				c.peak_lvl = 16'sh8000;
				c.first_left = 12'd4095;
				c.pulse_spacing = 12'd4095;
				c.ps_width = 12'd0;
				c.agc_width = 12'd0;
			end
			default: begin
				c.lines_625 = 1'($urandom_range(0, 1));
				c.tip_lvl = 16'($urandom_range(0, 65535));
				c.black_level = 16'($urandom_range(0, 65535));
				c.peak_lvl = 16'($urandom_range(0, 65535));
				c.first_left = 12'($urandom_range(0, 2000));
				c.pulse_spacing = 12'($urandom_range(0, 300));
				c.ps_width = 12'(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 100));
				c.agc_width = 12'(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150));
			end
		endcase
		return c;
	endfunction

	task automatic wait_idle();
		while (sb.samples_due.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, val);
	endtask

	task automatic apply_settings(agcpi_pkg::cfg_t c);
		wait_idle();
		cfg_write(agcpi_pkg::REG_LINES_625, {31'b0, c.lines_625});
		cfg_write(agcpi_pkg::REG_TIP_LVL, {{16{c.tip_lvl[15]}}, c.tip_lvl});
		cfg_write(agcpi_pkg::REG_BLACK_LEVEL, {{16{c.black_level[15]}}, c.black_level});
		cfg_write(agcpi_pkg::REG_PEAK_LVL, {{16{c.peak_lvl[15]}}, c.peak_lvl});
		cfg_write(agcpi_pkg::REG_FIRST_LEFT, {20'b0, c.first_left});
		cfg_write(agcpi_pkg::REG_PULSE_SPACING, {20'b0, c.pulse_spacing});
		cfg_write(agcpi_pkg::REG_PS_WIDTH, {20'b0, c.ps_width});
		cfg_write(agcpi_pkg::REG_AGC_WIDTH, {20'b0, c.agc_width});
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		settings_count++;
	endtask

	// sends the queued samples in bursts with random gaps
	task automatic send_samples();
		video_sample_t s;
		int burst;
		int gap;
		burst = $urandom_range(1, 16);
		while (samples_to_send.size() != 0) begin
			s = samples_to_send.pop_front();
			s_axis_tvalid <= 1'b1;
			s_axis_tdata <= {2'b00, s.smp, s.pixel, s.frame, s.line};
			s_axis_tuser <= s.taken;
			do @(posedge clk); while (!s_axis_tready);
			sb.note_input(s);
			samples_sent++;
			burst--;
			if (burst == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				if (gap != 0) begin
					s_axis_tvalid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) :
					$urandom_range(1, 16);
			end
		end
		s_axis_tvalid <= 1'b0;
	endtask

	initial begin
		agcpi_pkg::cfg_t c;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// overlapping pairs: spacing 50 is shorter than a 60 pixel pair
		c.lines_625 = 1'b1;
		c.tip_lvl = -16'sd8000;
		c.black_level = 16'sd0;
		c.peak_lvl = 16'sd20000;
		c.first_left = 12'd100;
		c.pulse_spacing = 12'd50;
		c.ps_width = 12'd20;
		c.agc_width = 12'd40;
		apply_settings(c);
		add_sample(1, 0, 0, 0, 0);
		add_sample(10, 0, 100, 32767, 0);
		add_sample(10, 0, 119, -1, 0);
		add_sample(10, 0, 120, 5, 0);
		add_sample(10, 0, 150, 7, 0);
		add_sample(9, 0, 99, -32768, 0);
		add_sample(18, 0, 409, 11, 0);
		add_sample(18, 0, 410, 12, 0);
		add_sample(330, 0, 4095, -32768, 0);
		add_sample(321, 0, 200, 100, 1);
		add_sample(8, 0, 130, 3, 0);
		add_sample(19, 0, 130, 4, 0);
		add_sample(1, 214, 0, 0, 0);
		add_sample(325, 214, 130, 9, 0);
		add_sample(1, 32'hffffffff, 4095, 1, 0);
		add_sample(12, 32'hffffffff, 125, 2, 0);
		add_sample(0, 0, 100, 6, 0);
		add_sample(1023, 0, 100, 6, 0);
		add_sample(626, 0, 100, 6, 0);
		add_sample(625, 0, 100, 6, 0);
		send_samples();

		// 525-line windows, zero-width pseudo-sync, inverted levels
		c.lines_625 = 1'b0;
		c.tip_lvl = 16'sd1000;
		c.black_level = -16'sd5000;
		c.peak_lvl = -16'sd20000;
		c.first_left = 12'd0;
		c.pulse_spacing = 12'd4095;
		c.ps_width = 12'd0;
		c.agc_width = 12'd30;
		apply_settings(c);
		add_sample(1, 277, 0, 0, 0);
		add_sample(12, 277, 0, 50, 0);
		add_sample(19, 277, 29, 51, 0);
		add_sample(275, 277, 30, 52, 0);
		add_sample(282, 277, 0, 53, 1);
		add_sample(11, 277, 0, 54, 0);
		add_sample(10, 277, 0, 55, 0);
		send_samples();

		for (int phase = 0; phase < 5; phase++) begin
			apply_settings(pick_settings(phase));
			repeat (85) samples_to_send.push_back(random_sample());
			send_samples();
		end

		wait_idle();
		$display("sent %0d samples over %0d register settings, checked %0d outputs",
			samples_sent, settings_count, sb.checked);
		$display("%0d samples on claimed lines, %0d of them overwritten by pulses",
			sb.claimed, sb.overwritten);
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire
